FILE: hdl/rau_pkg.sv
package rau_pkg;

  // Fixed port widths
  localparam int OP_W  = 4;
  localparam int NUM_W = 32;
  localparam int DEN_W = 31;
  localparam int ST_W  = 2;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;

  // Opcodes
  localparam op_t OP_ADD = 4'd0;
  localparam op_t OP_SUB = 4'd1;
  localparam op_t OP_MUL = 4'd2;
  localparam op_t OP_DIV = 4'd3;
  localparam op_t OP_NEG = 4'd4;
  localparam op_t OP_INC = 4'd5;
  localparam op_t OP_LT  = 4'd6;
  localparam op_t OP_LE  = 4'd7;
  localparam op_t OP_EQ  = 4'd8;
  localparam op_t OP_NE  = 4'd9;
  localparam op_t OP_GE  = 4'd10;
  localparam op_t OP_GT  = 4'd11;

  // Status codes
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_DIVZ = 2'd1;
  localparam status_t ST_OVF  = 2'd2;

endpackage

FILE: hdl/rau_mul.sv
// Shift-add unsigned multiplier, one multiplier bit per cycle.
module rau_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int CW = $clog2(W);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [W-1:0]   mplier;
  logic [2*W-1:0] mcand;
  logic [2*W-1:0] acc;

  assign prod = acc;

  // Add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Pulse done on the last multiplier bit
      done <= !start && busy && (cnt == CW'(W - 1));
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        mplier <= a;
        mcand  <= {{W{1'b0}}, b};
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: hdl/rau_gcd.sv
// Binary GCD of two nonzero values: one shift or subtract-and-shift per cycle.
module rau_gcd #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] g
);

  localparam logic [1:0] G_IDLE  = 2'd0;
  localparam logic [1:0] G_STRIP = 2'd1;
  localparam logic [1:0] G_LOOP  = 2'd2;
  localparam logic [1:0] G_SHL   = 2'd3;

  localparam int KW = $clog2(W);

  logic [1:0]    ph;
  logic [W-1:0]  u;
  logic [W-1:0]  v;
  logic [KW-1:0] k;

  assign g = u;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= G_IDLE;
      done <= 1'b0;
      k    <= '0;
    end else begin
      // Pulse done once the power of two is restored
      done <= (ph == G_SHL) && (k == '0);
      case (ph)
        G_IDLE: begin
          if (start) begin
            u  <= a;
            v  <= b;
            k  <= '0;
            ph <= G_STRIP;
          end
        end
        // Drop common factors of two
        G_STRIP: begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else begin
            ph <= G_LOOP;
          end
        end
        // Reduce until one side is zero
        G_LOOP: begin
          if (u == '0) begin
            u  <= v;
            ph <= G_SHL;
          end else if (v == '0) begin
            ph <= G_SHL;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= (u - v) >> 1;
          end else begin
            v <= (v - u) >> 1;
          end
        end
        // Restore the common power of two
        G_SHL: begin
          if (k == '0) begin
            ph <= G_IDLE;
          end else begin
            u <= u << 1;
            k <= k - 1'b1;
          end
        end
        default: ph <= G_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] n,
  input  logic [W-1:0] d,
  output logic         done,
  output logic [W-1:0] q
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W:0]    rem;
  logic [W-1:0]  dvs;
  logic [W:0]    rem_sh;
  logic          fits;

  assign rem_sh = {rem[W-1:0], q[W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Pulse done on the last quotient bit
      done <= !start && busy && (cnt == CW'(W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        q    <= n;
        dvs  <= d;
      end else if (busy) begin
        // Shift in the next dividend bit and subtract where it fits
        rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
        q   <= {q[W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: hdl/rational_arithmetic_unit.sv
// Channel  Handshake             Payload
// input    in_valid / in_ready   op, a_num, a_den, b_num, b_den
// output   out_valid / out_ready res_num, res_den, cond, status
//
// One transaction at a time; in_ready is high only while the sequencer idles.
// Arithmetic ops: three products in the serial multiplier, the combine and sign steps,
// the binary GCD (data dependent) on a nonzero result, and the two dividers running
// side by side. Ordering comparisons stop after the sign step. Errors, unused
// opcodes, eq and ne go straight from idle to the finish state.
// rst is synchronous and clears the sequencer and output valid; a result held
// by a low out_ready stalls the sequencer before it returns to idle.
module rational_arithmetic_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rau_pkg::OP_W-1:0]             op,
  input  logic signed [rau_pkg::NUM_W-1:0]     a_num,
  input  logic [rau_pkg::DEN_W-1:0]            a_den,
  input  logic signed [rau_pkg::NUM_W-1:0]     b_num,
  input  logic [rau_pkg::DEN_W-1:0]            b_den,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rau_pkg::NUM_W-1:0]     res_num,
  output logic [rau_pkg::DEN_W-1:0]            res_den,
  output logic                                 cond,
  output logic [rau_pkg::ST_W-1:0]             status
);

  localparam int DW   = DATA_WIDTH;
  localparam int PW   = 2 * DATA_WIDTH;
  localparam int NW   = rau_pkg::NUM_W;
  localparam int DENW = rau_pkg::DEN_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_MUL3 = 4'd3;
  localparam logic [3:0] S_COMB = 4'd4;
  localparam logic [3:0] S_SIGN = 4'd5;
  localparam logic [3:0] S_GCD  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [PW-1:0] LIM = PW'(1) << (DW - 1);

  logic [3:0]            state;
  logic                  kick;
  rau_pkg::op_t          op_r;
  logic                  sa, sb;
  logic [DW-1:0]         ma, mb;
  logic [DW-2:0]         ad_r, bd_r;
  logic [PW-1:0]         m1, m2, m3;
  logic [PW-1:0]         val;
  logic [PW-1:0]         mag_r, den_r;
  logic                  neg_r;
  logic [NW-1:0]         pend_num;
  logic [DENW-1:0]       pend_den;
  logic                  pend_cond;
  rau_pkg::status_t      pend_st;

  // Input fields at the configured width
  logic [DW-1:0] an_in, bn_in;
  logic [DW-2:0] ad_in, bd_in;
  assign an_in = a_num[DW-1:0];
  assign bn_in = b_num[DW-1:0];
  assign ad_in = a_den[DW-2:0];
  assign bd_in = b_den[DW-2:0];

  logic neg_un;
  assign neg_un = (op == rau_pkg::OP_NEG) || (op == rau_pkg::OP_INC);

  // Classify the incoming transaction
  logic in_divz, in_calc, in_cond, fields_eq;
  assign fields_eq = (an_in == bn_in) && (ad_in == bd_in);
  assign in_divz   = (op <= rau_pkg::OP_GT) &&
                     (ad_in == '0 || (!neg_un && bd_in == '0) ||
                      (op == rau_pkg::OP_DIV && bn_in == '0));
  assign in_calc   = (op <= rau_pkg::OP_GT) && !in_divz &&
                     (op != rau_pkg::OP_EQ) && (op != rau_pkg::OP_NE);
  assign in_cond   = !in_divz && ((op == rau_pkg::OP_EQ && fields_eq) ||
                                  (op == rau_pkg::OP_NE && !fields_eq));

  assign in_ready = (state == S_IDLE);

  // Arithmetic units; the multiplier is shared by all three products
  logic [DW-1:0]  mul_a, mul_b;
  logic           mul_done;
  logic [PW-1:0]  mul_p;
  logic           gcd_done;
  logic [PW-1:0]  gcd_g;
  logic           divn_done, divd_done;
  logic [PW-1:0]  divn_q, divd_q;
  logic           op_un_r;

  assign op_un_r = (op_r == rau_pkg::OP_NEG) || (op_r == rau_pkg::OP_INC);

  // Select multiplier operands for each product
  always_comb begin
    case (state)
      S_MUL1: begin
        mul_a = ma;
        if (op_r == rau_pkg::OP_MUL) mul_b = mb;
        else if (op_un_r)            mul_b = DW'(1);
        else                         mul_b = {1'b0, bd_r};
      end
      S_MUL2: begin
        mul_a = mb;
        mul_b = {1'b0, ad_r};
      end
      default: begin
        mul_a = {1'b0, ad_r};
        mul_b = op_un_r ? DW'(1) : {1'b0, bd_r};
      end
    endcase
  end

  rau_mul #(.W(DW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (kick && (state == S_MUL1 || state == S_MUL2 || state == S_MUL3)),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  rau_gcd #(.W(PW)) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (kick && state == S_GCD),
    .a     (mag_r),
    .b     (den_r),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rau_div #(.W(PW)) u_div_num (
    .clk   (clk),
    .rst   (rst),
    .start (kick && state == S_DIV),
    .n     (mag_r),
    .d     (gcd_g),
    .done  (divn_done),
    .q     (divn_q)
  );

  rau_div #(.W(PW)) u_div_den (
    .clk   (clk),
    .rst   (rst),
    .start (kick && state == S_DIV),
    .n     (den_r),
    .d     (gcd_g),
    .done  (divd_done),
    .q     (divd_q)
  );

  // Signed combine of the first product with the second, or with the third for inc
  logic [PW-1:0] p_s, q_s, comb_val;
  always_comb begin
    p_s = sa ? (~m1 + 1'b1) : m1;
    if (op_r == rau_pkg::OP_INC) q_s = m3;
    else                         q_s = sb ? (~m2 + 1'b1) : m2;
    if (op_r == rau_pkg::OP_ADD || op_r == rau_pkg::OP_INC) comb_val = p_s + q_s;
    else                                                    comb_val = p_s - q_s;
  end

  // Sign, magnitude and denominator of the unreduced result, or the comparison outcome
  logic          sg_neg, sg_zero, is_cmp, sg_cond;
  logic [PW-1:0] sg_mag, sg_den;
  always_comb begin
    sg_zero = (val == '0);
    is_cmp  = 1'b0;
    sg_cond = 1'b0;
    sg_neg  = val[PW-1];
    sg_mag  = val[PW-1] ? (~val + 1'b1) : val;
    sg_den  = m3;
    case (op_r)
      rau_pkg::OP_MUL: begin
        sg_neg = sa ^ sb;
        sg_mag = m1;
      end
      rau_pkg::OP_DIV: begin
        sg_neg = sa ^ sb;
        sg_mag = m1;
        sg_den = m2;
      end
      rau_pkg::OP_NEG: begin
        sg_neg = !sa;
        sg_mag = m1;
      end
      rau_pkg::OP_LT: begin
        is_cmp  = 1'b1;
        sg_cond = val[PW-1];
      end
      rau_pkg::OP_LE: begin
        is_cmp  = 1'b1;
        sg_cond = val[PW-1] || sg_zero;
      end
      rau_pkg::OP_GE: begin
        is_cmp  = 1'b1;
        sg_cond = !val[PW-1];
      end
      rau_pkg::OP_GT: begin
        is_cmp  = 1'b1;
        sg_cond = !val[PW-1] && !sg_zero;
      end
      default: ;
    endcase
  end

  // Start the unit or units of the next step
  logic kick_next;
  always_comb begin
    case (state)
      S_IDLE:  kick_next = in_valid && in_calc;
      S_MUL1,
      S_MUL2:  kick_next = mul_done;
      S_SIGN:  kick_next = !is_cmp && (sg_mag != '0);
      S_GCD:   kick_next = gcd_done;
      default: kick_next = 1'b0;
    endcase
  end

  // Range check and signed numerator of the reduced result
  logic          ovf;
  logic [PW-1:0] num_full;
  assign ovf      = (divd_q > LIM - 1'b1) || (divn_q > (neg_r ? LIM : LIM - 1'b1));
  assign num_full = neg_r ? (~divn_q + 1'b1) : divn_q;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kick      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      kick <= kick_next;
      // Raise output valid on a finished result, drop it once taken
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= op;
            sa        <= an_in[DW-1];
            sb        <= bn_in[DW-1];
            ma        <= an_in[DW-1] ? (~an_in + 1'b1) : an_in;
            mb        <= bn_in[DW-1] ? (~bn_in + 1'b1) : bn_in;
            ad_r      <= ad_in;
            bd_r      <= bd_in;
            pend_num  <= '0;
            pend_den  <= DENW'(1);
            pend_cond <= in_cond;
            pend_st   <= in_divz ? rau_pkg::ST_DIVZ : rau_pkg::ST_OK;
            state     <= in_calc ? S_MUL1 : S_FIN;
          end
        end
        S_MUL1: begin
          if (mul_done) begin
            m1    <= mul_p;
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_done) begin
            m2    <= mul_p;
            state <= S_MUL3;
          end
        end
        S_MUL3: begin
          if (mul_done) begin
            m3    <= mul_p;
            state <= S_COMB;
          end
        end
        S_COMB: begin
          val   <= comb_val;
          state <= S_SIGN;
        end
        S_SIGN: begin
          if (is_cmp) begin
            pend_cond <= sg_cond;
            state     <= S_FIN;
          end else if (sg_mag == '0) begin
            state <= S_FIN;
          end else begin
            mag_r <= sg_mag;
            den_r <= sg_den;
            neg_r <= sg_neg;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (divn_done && divd_done) begin
            if (ovf) begin
              pend_st <= rau_pkg::ST_OVF;
            end else begin
              pend_num <= NW'($signed(num_full[DW-1:0]));
              pend_den <= DENW'(divd_q[DW-2:0]);
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            res_num <= pend_num;
            res_den <= pend_den;
            cond    <= pend_cond;
            status  <= pend_st;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Error results carry 0/1 and no comparison outcome
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == rau_pkg::ST_DIVZ || status == rau_pkg::ST_OVF)
      |-> res_num == '0 && res_den == DENW'(1) && !cond)
    else $error("error result not cleared to 0/1");

  // A true comparison is an ok result with a zero numerator
  a_cond_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && cond |-> status == rau_pkg::ST_OK && res_num == '0)
    else $error("comparison result carries arithmetic fields");

  // A zero numerator is always reduced to a unit denominator
  a_zero_red: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_num == '0 |-> res_den == DENW'(1))
    else $error("zero result not reduced to 0/1");

  // The GCD only ever runs on a nonzero magnitude
  a_gcd_nz: assert property (@(posedge clk) disable iff (rst)
    state == S_GCD |-> mag_r != '0 && den_r != '0)
    else $error("GCD started on a zero operand");

endmodule

FILE: tb/sv/rational_arithmetic_unit_tb.sv
`timescale 1ns / 100ps

module rational_arithmetic_unit_tb;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  logic [rau_pkg::OP_W-1:0]         op;
  logic signed [rau_pkg::NUM_W-1:0] a_num;
  logic [rau_pkg::DEN_W-1:0]        a_den;
  logic signed [rau_pkg::NUM_W-1:0] b_num;
  logic [rau_pkg::DEN_W-1:0]        b_den;
  logic                             out_valid;
  logic                             out_ready;
  logic signed [rau_pkg::NUM_W-1:0] res_num;
  logic [rau_pkg::DEN_W-1:0]        res_den;
  logic                             cond;
  logic [rau_pkg::ST_W-1:0]         status;

  typedef struct packed {
    logic signed [rau_pkg::NUM_W-1:0] num;
    logic [rau_pkg::DEN_W-1:0]        den;
    logic                             c;
    rau_pkg::status_t                 st;
  } ratio_res_t;

  ratio_res_t expected_q[$];
  int         n_errors;
  int         send_idle_pct;
  int         recv_stall_pct;

  rational_arithmetic_unit #(.DATA_WIDTH(32)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_num(res_num), .res_den(res_den), .cond(cond), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reduce a signed magnitude over a positive denominator, or flag overflow
  function automatic ratio_res_t reduce_ratio(bit neg, logic [63:0] mag, logic [63:0] den);
    ratio_res_t  r;
    logic [63:0] x, y, t;
    r = '{num: '0, den: 31'd1, c: 1'b0, st: rau_pkg::ST_OK};
    if (mag == 0) return r;
    x = mag;
    y = den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    mag = mag / x;
    den = den / x;
    if (den > 64'h7FFF_FFFF || mag > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
      r.st = rau_pkg::ST_OVF;
      return r;
    end
    r.num = neg ? -mag[31:0] : mag[31:0];
    r.den = den[30:0];
    return r;
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Compute the expected result of one operation
  function automatic ratio_res_t rational_result(rau_pkg::op_t o, logic signed [31:0] an,
                                                 logic [30:0] ad, logic signed [31:0] bn,
                                                 logic [30:0] bd);
    ratio_res_t        r;
    logic signed [63:0] san, sbn, sad, sbd, p, q, s;
    r = '{num: '0, den: 31'd1, c: 1'b0, st: rau_pkg::ST_OK};
    san = an;
    sbn = bn;
    sad = {33'd0, ad};
    sbd = {33'd0, bd};
    if (o > rau_pkg::OP_GT) return r;
    if (ad == 0 || (o != rau_pkg::OP_NEG && o != rau_pkg::OP_INC && bd == 0)) begin
      r.st = rau_pkg::ST_DIVZ;
      return r;
    end
    p = san * sbd;
    q = sbn * sad;
    case (o)
      rau_pkg::OP_ADD: begin
        s = p + q;
        return reduce_ratio(s < 0, abs64(s), sad * sbd);
      end
      rau_pkg::OP_SUB: begin
        s = p - q;
        return reduce_ratio(s < 0, abs64(s), sad * sbd);
      end
      rau_pkg::OP_MUL: begin
        s = san * sbn;
        return reduce_ratio(s < 0, abs64(s), sad * sbd);
      end
      rau_pkg::OP_DIV: begin
        if (bn == 0) begin
          r.st = rau_pkg::ST_DIVZ;
          return r;
        end
        return reduce_ratio((p < 0) != (sbn < 0), abs64(p), abs64(sbn) * sad);
      end
      rau_pkg::OP_NEG: return reduce_ratio(!(san < 0), abs64(san), sad);
      rau_pkg::OP_INC: begin
        s = san + sad;
        return reduce_ratio(s < 0, abs64(s), sad);
      end
      rau_pkg::OP_LT: r.c = p < q;
      rau_pkg::OP_LE: r.c = p <= q;
      rau_pkg::OP_EQ: r.c = (an == bn) && (ad == bd);
      rau_pkg::OP_NE: r.c = !((an == bn) && (ad == bd));
      rau_pkg::OP_GE: r.c = p >= q;
      default: r.c = p > q;
    endcase
    return r;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_item(rau_pkg::op_t o, logic [31:0] an, logic [30:0] ad,
                           logic [31:0] bn, logic [30:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    a_num    <= an;
    a_den    <= ad;
    b_num    <= bn;
    b_den    <= bd;
    expected_q.push_back(rational_result(o, an, ad, bn, bd));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Randomize receiver stalls at each falling edge
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    ratio_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no expectation: num %0d den %0d", res_num, res_den);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (res_num !== e.num) begin
          $error("res_num expected %0d actual %0d", e.num, res_num);
          n_errors++;
        end
        if (res_den !== e.den) begin
          $error("res_den expected %0d actual %0d", e.den, res_den);
          n_errors++;
        end
        if (cond !== e.c) begin
          $error("cond expected %0d actual %0d", e.c, cond);
          n_errors++;
        end
        if (status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status);
          n_errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_num();
    case ($urandom_range(4))
      0: return $urandom_range(20) - 10;
      1: return $urandom_range(2000) - 1000;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(5))
      0: return 31'($urandom_range(12));
      1: return 31'($urandom_range(1000));
      2: return 31'($urandom_range(65535));
      3: return 31'h7FFF_FFFF;
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    rau_pkg::op_t o;
    send_item(rau_pkg::OP_ADD, 32'h7FFF_FFFF, 31'd1, 32'd1, 31'd1);
    send_item(rau_pkg::OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
    send_item(rau_pkg::OP_SUB, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
    send_item(rau_pkg::OP_SUB, 32'd3, 31'd4, 32'd3, 31'd4);
    send_item(rau_pkg::OP_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    send_item(rau_pkg::OP_MUL, -32'sd6, 31'd4, 32'd2, 31'd3);
    send_item(rau_pkg::OP_DIV, 32'd1, 31'd2, 32'd0, 31'd5);
    send_item(rau_pkg::OP_DIV, 32'd3, 31'h7FFF_FFFF, -32'sd7, 31'h7FFF_FFFF);
    send_item(rau_pkg::OP_NEG, 32'h8000_0000, 31'd1, 32'd0, 31'd0);
    send_item(rau_pkg::OP_NEG, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'd0, 31'd1);
    send_item(rau_pkg::OP_INC, 32'h7FFF_FFFF, 31'd1, 32'd0, 31'd0);
    send_item(rau_pkg::OP_INC, -32'sd5, 31'd5, 32'd0, 31'd1);
    send_item(rau_pkg::OP_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
    send_item(rau_pkg::OP_LT, 32'd1, 31'd1, 32'd1, 31'd0);
    send_item(rau_pkg::OP_EQ, 32'd2, 31'd4, 32'd1, 31'd2);
    send_item(rau_pkg::OP_EQ, 32'd1, 31'd2, 32'd1, 31'd2);
    for (int i = rau_pkg::OP_LT; i <= rau_pkg::OP_GT; i++) begin
      o = rau_pkg::op_t'(i);
      send_item(o, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    end
    for (int i = 12; i < 16; i++) begin
      send_item(rau_pkg::op_t'(i), 32'd1, 31'd0, 32'd1, 31'd0);
    end
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_item(rau_pkg::op_t'($urandom_range(99) < 95 ? $urandom_range(11)
                                                      : $urandom_range(15)),
                rand_num(), rand_den(), rand_num(), rand_den());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Release reset, then step through the idling phases
  initial begin
    n_errors       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    out_ready = 1'b0;
    op        = '0;
    a_num     = '0;
    a_den     = 31'd1;
    b_num     = '0;
    b_den     = 31'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(400);
    send_idle_pct = 58;
    test_random(370);
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    test_random(370);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    test_random(370);
    wait_drained();
    if (n_errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/rau_pkg.sv
hdl/rau_mul.sv
hdl/rau_gcd.sv
hdl/rau_div.sv
hdl/rational_arithmetic_unit.sv
tb/sv/rational_arithmetic_unit_tb.sv
